[hw/rtl/vbf_pkg.sv]
`timescale 1ns / 1ps

package vbf_pkg;

  localparam int SAMPLE_W   = 25;
  localparam int STATE_W    = 32;
  localparam int MEAN_W     = 40;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 16;
  localparam int OPA_W      = 41;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = 66;
  localparam int ACC_W      = 51;
  localparam int BAND_W     = 33;
  localparam int VAL_W      = 34;
  localparam int CLAMP_W    = 30;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IDX_W      = 2;
  localparam int NUM_POLES  = 3;
  localparam int BAND_CNT   = 4;

  localparam logic [COEF_W-1:0] K_DC     = 24'd16777;
  localparam logic [COEF_W-1:0] K_HP     = 24'd16139682;
  localparam logic [COEF_W-1:0] K_LP     = 24'd5469372;
  localparam logic [COEF_W-1:0] K_SPLIT0 = 24'd1375732;
  localparam logic [COEF_W-1:0] K_SPLIT1 = 24'd2634023;
  localparam logic [COEF_W-1:0] K_SPLIT2 = 24'd4513071;
  localparam logic [COEF_W-1:0] K_TENTH  = 24'd1677722;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1311;

  localparam logic signed [VAL_W-1:0]   ONE_Q28    = 34'sd268435456;
  localparam logic signed [VAL_W-1:0]   MINUS_Q28  = -34'sd268435456;
  localparam logic signed [OUT_W-1:0]   OUT_MAX    = 16'sd32767;

  typedef enum logic {
    OP_ANALYZE = 1'b0,
    OP_SYNTH   = 1'b1
  } op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_LOW     = 3'd0,
    REG_GAIN_LOWMID  = 3'd1,
    REG_GAIN_HIGHMID = 3'd2,
    REG_GAIN_HIGH    = 3'd3,
    REG_SPEECH       = 3'd4
  } reg_idx_e;

  typedef logic signed [PROD_W-1:0] wide_t;

  typedef struct packed {
    logic                    load;
    logic signed [OPA_W-1:0] a;
    logic [COEF_W-1:0]       b;
  } mul_req_t;

  function automatic wide_t rnd_shr(input wide_t v, input int n);
    return (v + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic wide_t sat_s(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

[hw/rtl/vbf_if.sv]
`timescale 1ns / 1ps

interface vbf_in_if import vbf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface vbf_out_if import vbf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic signed [SAMPLE_W-1:0] band_0;
  logic signed [SAMPLE_W-1:0] band_1;
  logic signed [SAMPLE_W-1:0] band_2;
  logic signed [SAMPLE_W-1:0] band_3;
  logic signed [OUT_W-1:0]    processed;

  modport source (output valid, output filtered, output band_0, output band_1,
                  output band_2, output band_3, output processed, input ready);
  modport sink   (input valid, input filtered, input band_0, input band_1,
                  input band_2, input band_3, input processed, output ready);
endinterface

interface vbf_cfg_if import vbf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/voice_band_filter_and_gain_top.sv]
`timescale 1ns / 1ps
// Voice-band filter and gain.
// in_i carries one beat per sample: operation selects analyze (DC removal,
// high-pass, low-pass, then band split) or synthesize (band split of a
// filtered sample, band gains, x4, optional x0.1, clamp to 16 bits).
// out_o returns exactly one beat per input beat, in order.
// cfg_i writes the four band gains (index 0..3) and speech_active (index 4);
// higher indexes are dropped. It is always ready; write only while idle.
// One shared 41x24 multiplier, fed and drained by a small sequencer, does
// every product through its operand, multiply and update steps.
// in_i is ready only while the sequencer is idle, so no new sample is taken
// until the previous result has been written to the output register.
// The result sits in an output register; a stalled receiver holds it there
// while the next beat is already being worked on, and the sequencer waits
// at its final step only if the register is still full.
// Reset clears all filter states, sets the gains to 1311 and speech_active
// to 0; there is no clearing pass.

module voice_band_filter_and_gain_top import vbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  vbf_cfg_if.sink   cfg_i,
  vbf_in_if.sink    in_i,
  vbf_out_if.source out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_DIFF,
    ST_HP,
    ST_LP,
    ST_FILT,
    ST_SPLIT,
    ST_GAIN,
    ST_SCALE,
    ST_TENTH,
    ST_FINAL
  } state_e;

  typedef enum logic [1:0] {
    PH_OPND,
    PH_MULT,
    PH_UPDT
  } phase_e;

  state_e                     state_q;
  phase_e                     phase_q;
  logic [IDX_W-1:0]           idx_q;
  op_e                        op_q;
  logic signed [SAMPLE_W-1:0] xin_q;
  logic signed [MEAN_W-1:0]   dc_mean_q;
  logic signed [BAND_W-1:0]   d_q;
  logic signed [STATE_W-1:0]  hp_in_q;
  logic signed [STATE_W-1:0]  hp_out_q;
  logic signed [STATE_W-1:0]  lp_q;
  logic signed [STATE_W-1:0]  spa_q [NUM_POLES];
  logic signed [STATE_W-1:0]  sps_q [NUM_POLES];
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [VAL_W-1:0]    v_q;
  logic [GAIN_W-1:0]          gain_q [BAND_CNT];
  logic                       speech_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic signed [SAMPLE_W-1:0] band_q [BAND_CNT];
  logic signed [OUT_W-1:0]    processed_q;

  mul_req_t                   mul_req;
  wide_t                      prod_w;
  wide_t                      step_w;
  logic signed [29:0]         x_w;
  logic signed [STATE_W-1:0]  sp_w [NUM_POLES];
  logic signed [STATE_W-1:0]  s_cur;
  logic signed [BAND_W-1:0]   band_w [BAND_CNT];
  logic [COEF_W-1:0]          coef_sel;
  wide_t                      dc_next;
  wide_t                      d_next;
  wide_t                      h_next;
  wide_t                      hp_in_next;
  wide_t                      lp_next;
  wide_t                      f_next;
  wide_t                      s_next;
  wide_t                      v_scaled;
  wide_t                      band_out [BAND_CNT];
  logic signed [CLAMP_W-1:0]  vc_w;
  logic signed [CLAMP_W-1:0]  t_w;
  logic signed [CLAMP_W-1:0]  p_w;
  logic signed [OUT_W-1:0]    proc_w;
  logic                       in_fire;
  logic                       out_free;

  vbf_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod_w)
  );

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign x_w      = $signed({xin_q, 5'b00000});
  assign step_w   = rnd_shr(prod_w, 24);

  always_comb begin
    for (int k = 0; k < NUM_POLES; k++) begin
      sp_w[k] = (op_q == OP_SYNTH) ? sps_q[k] : spa_q[k];
    end
    case (idx_q)
      2'd0: begin
        s_cur    = sp_w[0];
        coef_sel = K_SPLIT0;
      end
      2'd1: begin
        s_cur    = sp_w[1];
        coef_sel = K_SPLIT1;
      end
      default: begin
        s_cur    = sp_w[2];
        coef_sel = K_SPLIT2;
      end
    endcase
    band_w[0] = BAND_W'(sp_w[0]);
    band_w[1] = BAND_W'(sp_w[1]) - BAND_W'(sp_w[0]);
    band_w[2] = BAND_W'(sp_w[2]) - BAND_W'(sp_w[1]);
    band_w[3] = BAND_W'(x_w) - BAND_W'(sp_w[2]);
  end

  always_comb begin
    mul_req.load = (phase_q == PH_OPND) &&
                   (state_q == ST_DC || state_q == ST_HP || state_q == ST_LP ||
                    state_q == ST_SPLIT || state_q == ST_GAIN || state_q == ST_TENTH);
    mul_req.a    = '0;
    mul_req.b    = '0;
    case (state_q)
      ST_DC: begin
        mul_req.a = OPA_W'($signed({xin_q, 13'b0})) - OPA_W'(dc_mean_q);
        mul_req.b = K_DC;
      end
      ST_HP: begin
        mul_req.a = OPA_W'(hp_out_q) + OPA_W'(d_q) - OPA_W'(hp_in_q);
        mul_req.b = K_HP;
      end
      ST_LP: begin
        mul_req.a = OPA_W'(hp_out_q) - OPA_W'(lp_q);
        mul_req.b = K_LP;
      end
      ST_SPLIT: begin
        mul_req.a = OPA_W'(x_w) - OPA_W'(s_cur);
        mul_req.b = coef_sel;
      end
      ST_GAIN: begin
        mul_req.a = OPA_W'(band_w[idx_q]);
        mul_req.b = COEF_W'(gain_q[idx_q]);
      end
      ST_TENTH: begin
        mul_req.a = OPA_W'(v_q);
        mul_req.b = K_TENTH;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    dc_next    = sat_s(wide_t'(dc_mean_q) + step_w, MEAN_W);
    d_next     = wide_t'(x_w) - rnd_shr(wide_t'(dc_mean_q), 8);
    h_next     = sat_s(step_w, STATE_W);
    hp_in_next = sat_s(wide_t'(d_q), STATE_W);
    lp_next    = sat_s(wide_t'(lp_q) + step_w, STATE_W);
    f_next     = sat_s(rnd_shr(wide_t'(lp_q), 5), SAMPLE_W);
    s_next     = sat_s(wide_t'(s_cur) + step_w, STATE_W);
    v_scaled   = sat_s(rnd_shr(wide_t'(acc_q), 16) <<< 2, VAL_W);
    for (int k = 0; k < BAND_CNT; k++) begin
      band_out[k] = sat_s(rnd_shr(wide_t'(band_w[k]), 5), SAMPLE_W);
    end
  end

  always_comb begin
    if (v_q > ONE_Q28) begin
      vc_w = CLAMP_W'(ONE_Q28);
    end else if (v_q < MINUS_Q28) begin
      vc_w = CLAMP_W'(MINUS_Q28);
    end else begin
      vc_w = CLAMP_W'(v_q);
    end
    t_w = (vc_w + (vc_w[CLAMP_W-1] ? 30'sd31 : 30'sd0)) >>> 5;
    p_w = t_w >>> 8;
    if (vc_w == CLAMP_W'(ONE_Q28)) begin
      proc_w = OUT_MAX;
    end else begin
      proc_w = p_w[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_OPND;
      idx_q       <= '0;
      op_q        <= OP_ANALYZE;
      xin_q       <= '0;
      dc_mean_q   <= '0;
      d_q         <= '0;
      hp_in_q     <= '0;
      hp_out_q    <= '0;
      lp_q        <= '0;
      acc_q       <= '0;
      v_q         <= '0;
      for (int k = 0; k < NUM_POLES; k++) begin
        spa_q[k] <= '0;
        sps_q[k] <= '0;
      end
      for (int k = 0; k < BAND_CNT; k++) begin
        gain_q[k] <= GAIN_RESET;
        band_q[k] <= '0;
      end
      speech_q    <= 1'b0;
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
      processed_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_GAIN_LOW:     gain_q[0] <= cfg_i.data;
          REG_GAIN_LOWMID:  gain_q[1] <= cfg_i.data;
          REG_GAIN_HIGHMID: gain_q[2] <= cfg_i.data;
          REG_GAIN_HIGH:    gain_q[3] <= cfg_i.data;
          REG_SPEECH:       speech_q  <= cfg_i.data[0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != ST_FINAL) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q    <= op_e'(in_i.operation);
            xin_q   <= in_i.sample;
            acc_q   <= '0;
            idx_q   <= '0;
            phase_q <= PH_OPND;
            state_q <= (op_e'(in_i.operation) == OP_SYNTH) ? ST_SPLIT : ST_DC;
          end
        end
        ST_DIFF: begin
          d_q     <= d_next[BAND_W-1:0];
          state_q <= ST_HP;
        end
        ST_FILT: begin
          xin_q   <= f_next[SAMPLE_W-1:0];
          state_q <= ST_SPLIT;
        end
        ST_SCALE: begin
          v_q     <= v_scaled[VAL_W-1:0];
          state_q <= speech_q ? ST_FINAL : ST_TENTH;
        end
        ST_FINAL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (op_q == OP_SYNTH) begin
              filtered_q  <= '0;
              for (int k = 0; k < BAND_CNT; k++) begin
                band_q[k] <= '0;
              end
              processed_q <= proc_w;
            end else begin
              filtered_q  <= xin_q;
              for (int k = 0; k < BAND_CNT; k++) begin
                band_q[k] <= band_out[k][SAMPLE_W-1:0];
              end
              processed_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          case (phase_q)
            PH_OPND: phase_q <= PH_MULT;
            PH_MULT: phase_q <= PH_UPDT;
            default: begin
              phase_q <= PH_OPND;
              case (state_q)
                ST_DC: begin
                  dc_mean_q <= dc_next[MEAN_W-1:0];
                  state_q   <= ST_DIFF;
                end
                ST_HP: begin
                  hp_out_q <= h_next[STATE_W-1:0];
                  hp_in_q  <= hp_in_next[STATE_W-1:0];
                  state_q  <= ST_LP;
                end
                ST_LP: begin
                  lp_q    <= lp_next[STATE_W-1:0];
                  state_q <= ST_FILT;
                end
                ST_SPLIT: begin
                  if (op_q == OP_SYNTH) begin
                    sps_q[idx_q] <= s_next[STATE_W-1:0];
                  end else begin
                    spa_q[idx_q] <= s_next[STATE_W-1:0];
                  end
                  if (idx_q == IDX_W'(NUM_POLES - 1)) begin
                    idx_q   <= '0;
                    state_q <= (op_q == OP_SYNTH) ? ST_GAIN : ST_FINAL;
                  end else begin
                    idx_q <= idx_q + 1'b1;
                  end
                end
                ST_GAIN: begin
                  acc_q <= acc_q + $signed(prod_w[ACC_W-1:0]);
                  if (idx_q == IDX_W'(BAND_CNT - 1)) begin
                    idx_q   <= '0;
                    state_q <= ST_SCALE;
                  end else begin
                    idx_q <= idx_q + 1'b1;
                  end
                end
                ST_TENTH: begin
                  v_q     <= step_w[VAL_W-1:0];
                  state_q <= ST_FINAL;
                end
                default: begin
                  state_q <= ST_IDLE;
                end
              endcase
            end
          endcase
        end
      endcase
    end
  end

  assign cfg_i.ready     = 1'b1;
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.filtered  = filtered_q;
  assign out_o.band_0    = band_q[0];
  assign out_o.band_1    = band_q[1];
  assign out_o.band_2    = band_q[2];
  assign out_o.band_3    = band_q[3];
  assign out_o.processed = processed_q;

endmodule

[hw/rtl/vbf_mul.sv]
`timescale 1ns / 1ps

module vbf_mul import vbf_pkg::*; (
  input  logic     clk_i,
  input  mul_req_t req_i,
  output wide_t    prod_o
);

  logic signed [OPA_W-1:0] a_q;
  logic [COEF_W-1:0]       b_q;
  wide_t                   prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    prod_q <= a_q * $signed({1'b0, b_q});
  end

  assign prod_o = prod_q;

endmodule

[verif/voice_band_filter_and_gain_top_test.sv]
`timescale 1ns / 1ps

module voice_band_filter_and_gain_top_test;
  import vbf_pkg::*;

  localparam int          CYCLE_LIMIT        = 400000;
  localparam int          HOLD_OFF_CYCLES    = 300;
  localparam int          SETTLE_CYCLES      = 40;
  localparam int          RANDOM_PHASES      = 6;
  localparam int          RANDOM_PHASE_ITEMS = 200;
  localparam logic [GAIN_W-1:0] GAIN_MAX     = '1;
  localparam logic [GAIN_W-1:0] GAIN_ZERO    = '0;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic signed [SAMPLE_W-1:0] band_0;
    logic signed [SAMPLE_W-1:0] band_1;
    logic signed [SAMPLE_W-1:0] band_2;
    logic signed [SAMPLE_W-1:0] band_3;
    logic signed [OUT_W-1:0]    processed;
  } vbf_result_t;

  class vbf_sample_scoreboard;
    localparam longint DC_STEP  = 16777;
    localparam longint HP_COEF  = 16139682;
    localparam longint LP_COEF  = 5469372;
    localparam longint TENTH    = 1677722;
    localparam longint MAX32    = 64'sd2147483647;
    localparam longint MIN32    = -64'sd2147483648;
    localparam longint MAX40    = 64'sd549755813887;
    localparam longint MIN40    = -64'sd549755813888;
    localparam longint MAX25    = 64'sd16777215;
    localparam longint MIN25    = -64'sd16777216;
    localparam longint FULL_Q28 = 64'sd268435456;

    longint      gain [4];
    logic        speech;
    longint      split_coef [3];
    longint      dc_mean;
    longint      hp_in;
    longint      hp_out;
    longint      lp_state;
    longint      split_an [3];
    longint      split_syn [3];
    vbf_result_t pending_results [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned analyzed;
    int unsigned synthesized;
    int unsigned output_clamps;
    int unsigned filter_saturations;
    int unsigned reg_writes;

    function new();
      for (int k = 0; k < 4; k++) gain[k] = 1311;
      split_coef[0] = 1375732;
      split_coef[1] = 2634023;
      split_coef[2] = 4513071;
      speech = 1'b0;
      dc_mean = 0;
      hp_in = 0;
      hp_out = 0;
      lp_state = 0;
      for (int k = 0; k < 3; k++) begin
        split_an[k] = 0;
        split_syn[k] = 0;
      end
    endfunction

    static function longint round_shr(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_GAIN_LOW:     gain[0] = longint'(data);
        REG_GAIN_LOWMID:  gain[1] = longint'(data);
        REG_GAIN_HIGHMID: gain[2] = longint'(data);
        REG_GAIN_HIGH:    gain[3] = longint'(data);
        REG_SPEECH:       speech = data[0];
        default: ;
      endcase
    endfunction

    function void run_split(bit synth_copy, longint x, output longint band [4]);
      longint st [3];
      for (int k = 0; k < 3; k++) st[k] = synth_copy ? split_syn[k] : split_an[k];
      for (int k = 0; k < 3; k++)
        st[k] = clip(st[k] + round_shr((x - st[k]) * split_coef[k], 24), MIN32, MAX32);
      band[0] = st[0];
      band[1] = st[1] - st[0];
      band[2] = st[2] - st[1];
      band[3] = x - st[2];
      for (int k = 0; k < 3; k++) begin
        if (synth_copy) split_syn[k] = st[k];
        else split_an[k] = st[k];
      end
    endfunction

    function vbf_result_t note_sample(op_e op, logic signed [SAMPLE_W-1:0] value);
      longint      s;
      longint      d;
      longint      h;
      longint      f;
      longint      acc;
      longint      v;
      longint      t;
      longint      p;
      longint      band [4];
      longint      b [4];
      vbf_result_t r;
      r = '0;
      s = value;
      if (op == OP_ANALYZE) begin
        analyzed++;
        dc_mean = clip(dc_mean + round_shr((s * 8192 - dc_mean) * DC_STEP, 24), MIN40, MAX40);
        d = s * 32 - round_shr(dc_mean, 8);
        h = round_shr((hp_out + d - hp_in) * HP_COEF, 24);
        if (h > MAX32 || h < MIN32) filter_saturations++;
        h = clip(h, MIN32, MAX32);
        hp_in = clip(d, MIN32, MAX32);
        hp_out = h;
        lp_state = clip(lp_state + round_shr((h - lp_state) * LP_COEF, 24), MIN32, MAX32);
        f = round_shr(lp_state, 5);
        if (f > MAX25 || f < MIN25) filter_saturations++;
        f = clip(f, MIN25, MAX25);
        run_split(1'b0, f * 32, band);
        for (int k = 0; k < 4; k++) b[k] = clip(round_shr(band[k], 5), MIN25, MAX25);
        r.filtered = f[SAMPLE_W-1:0];
        r.band_0 = b[0][SAMPLE_W-1:0];
        r.band_1 = b[1][SAMPLE_W-1:0];
        r.band_2 = b[2][SAMPLE_W-1:0];
        r.band_3 = b[3][SAMPLE_W-1:0];
      end else begin
        synthesized++;
        run_split(1'b1, s * 32, band);
        acc = band[0] * gain[0] + band[1] * gain[1] + band[2] * gain[2] + band[3] * gain[3];
        v = round_shr(acc, 16) * 4;
        if (!speech) v = round_shr(v * TENTH, 24);
        if (v >= FULL_Q28 || v <= -FULL_Q28) output_clamps++;
        v = clip(v, -FULL_Q28, FULL_Q28);
        t = (v >= 0) ? (v >>> 5) : -((-v) >>> 5);
        p = t >>> 8;
        if (p > 32767) p = 32767;
        r.processed = p[OUT_W-1:0];
      end
      pending_results.push_back(r);
      return r;
    endfunction

    function void compare_field(string field, logic signed [SAMPLE_W-1:0] want,
                                logic signed [SAMPLE_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_beat(vbf_result_t seen);
      vbf_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no sample outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("filtered", want.filtered, seen.filtered);
      compare_field("band_0", want.band_0, seen.band_0);
      compare_field("band_1", want.band_1, seen.band_1);
      compare_field("band_2", want.band_2, seen.band_2);
      compare_field("band_3", want.band_3, seen.band_3);
      compare_field("processed", want.processed, seen.processed);
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;

  vbf_sample_scoreboard sb;

  vbf_cfg_if cfg_bus ();
  vbf_in_if  in_bus ();
  vbf_out_if out_bus ();

  voice_band_filter_and_gain_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    vbf_result_t seen;
    int          hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        seen.filtered  = out_bus.filtered;
        seen.band_0    = out_bus.band_0;
        seen.band_1    = out_bus.band_1;
        seen.band_2    = out_bus.band_2;
        seen.band_3    = out_bus.band_3;
        seen.processed = out_bus.processed;
        sb.check_beat(seen);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4:          return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
      5:          return SAMPLE_MAX;
      6:          return SAMPLE_MIN;
      default:    return SAMPLE_W'($urandom_range(0, 16777215));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_ZERO;
      1:       return GAIN_MAX;
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_sample(input op_e op, input logic signed [SAMPLE_W-1:0] value,
                             output vbf_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.sample    <= value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    want = sb.note_sample(op, value);
  endtask

  // replay the filtered sample through synthesis
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] value);
    vbf_result_t want;
    send_sample(OP_ANALYZE, value, want);
    send_sample(OP_SYNTH, want.filtered, want);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [GAIN_W-1:0] g_low, input logic [GAIN_W-1:0] g_lowmid,
                              input logic [GAIN_W-1:0] g_highmid,
                              input logic [GAIN_W-1:0] g_high, input logic speech);
    logic [REG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] value [6];
    idx[0] = REG_GAIN_LOW;     value[0] = g_low;
    idx[1] = REG_GAIN_LOWMID;  value[1] = g_lowmid;
    idx[2] = REG_GAIN_HIGHMID; value[2] = g_highmid;
    idx[3] = REG_GAIN_HIGH;    value[3] = g_high;
    idx[4] = REG_SPEECH;       value[4] = {(CFG_DATA_W-1)'($urandom), speech};
    idx[5] = REG_IDX_W'($urandom_range(REG_SPEECH + 1, (1 << REG_IDX_W) - 1));
    value[5] = CFG_DATA_W'($urandom);
    for (int k = 0; k < 6; k++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[k];
      cfg_bus.data  <= value[k];
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
      sb.write_reg(idx[k], value[k]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic stream_random(input int items);
    vbf_result_t                want;
    logic signed [SAMPLE_W-1:0] level;
    int                         sent;
    int                         run;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          send_pair(rand_sample());
          sent += 2;
        end
        7: begin
          // square wave at full scale to push the filters into saturation
          level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          run = $urandom_range(2, 8);
          repeat ($urandom_range(1, 3)) begin
            repeat (run) send_pair(level);
            level = (level == SAMPLE_MAX) ? SAMPLE_MIN : SAMPLE_MAX;
            sent += 2 * run;
          end
        end
        default: begin
          send_sample($urandom_range(0, 1) ? OP_SYNTH : OP_ANALYZE, rand_sample(), want);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    vbf_result_t want;
    int          p;
    sb = new();
    in_bus.valid      = 1'b0;
    in_bus.operation  = OP_ANALYZE;
    in_bus.sample     = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_GAIN_LOW;
    cfg_bus.data      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair('0);
    send_pair(SAMPLE_MAX);
    send_pair(SAMPLE_MAX);
    send_pair(SAMPLE_MIN);
    send_pair(SAMPLE_MIN);
    send_pair(-1);
    send_sample(OP_SYNTH, SAMPLE_MAX, want);
    send_sample(OP_SYNTH, SAMPLE_MIN, want);
    send_sample(OP_ANALYZE, 1, want);

    // full gain with speech: +1.0 saturates to the top code, -1.0 holds
    drain_results();
    program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
    send_sample(OP_SYNTH, SAMPLE_MAX, want);
    send_sample(OP_SYNTH, SAMPLE_MAX, want);
    send_sample(OP_SYNTH, SAMPLE_MIN, want);
    send_sample(OP_SYNTH, SAMPLE_MIN, want);

    drain_results();
    program_regs(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 1'b0);
    send_sample(OP_SYNTH, SAMPLE_MAX, want);
    send_sample(OP_SYNTH, SAMPLE_MIN, want);

    drain_results();
    program_regs(GAIN_MAX, GAIN_ZERO, GAIN_MAX, GAIN_ZERO, 1'b1);
    send_pair(SAMPLE_MAX);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 38 : (p < 4) ? 57 : 0;
      recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 38 : 0;
      drain_results();
      if (p == 1) begin
        program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
      end else if (p == 3) begin
        program_regs(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, 1'b0);
      end else begin
        program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), 1'($urandom));
      end
      if (p == 2) begin
        stream_random(30);
        hold_request = HOLD_OFF_CYCLES;
        stream_random(RANDOM_PHASE_ITEMS - 30);
      end else begin
        stream_random(RANDOM_PHASE_ITEMS);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d analyze and %0d synthesize beats, %0d results compared",
             sb.analyzed, sb.synthesized, sb.checked);
    $display("%0d output clamps, %0d filter saturations, %0d register writes",
             sb.output_clamps, sb.filter_saturations, sb.reg_writes);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/vbf_pkg.sv
hw/rtl/vbf_if.sv
hw/rtl/vbf_mul.sv
hw/rtl/voice_band_filter_and_gain_top.sv
verif/voice_band_filter_and_gain_top_test.sv
